### hw/rtl/ises_pkg.sv
// Shared types and state codes for the insertion sort engine.
`default_nettype none

package ises_pkg;

  // Engine phase: load values into the chain, or drain the sorted set.
  typedef enum logic [0:0] {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } ises_state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the broadcast key
    logic shift;  // move every entry one cell toward the output
  } ises_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/ises_cell.sv
// One cell of the sorting chain: holds one entry and trades with its neighbors.
`default_nettype none

module ises_cell #(
  parameter int W = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ises_pkg::ises_ctrl_t ctrl,
  input  wire logic [W-1:0]      key,
  // neighbor toward the output end (lower index)
  input  wire logic [W-1:0]      prev_value,
  input  wire logic              prev_valid,
  input  wire logic              prev_le,
  // neighbor away from the output end (higher index)
  input  wire logic [W-1:0]      next_value,
  input  wire logic              next_valid,
  // own entry
  output logic [W-1:0]           value,
  output logic                   valid,
  output logic                   le
);

  logic [W-1:0] value_next;
  logic         valid_next;

  // Entry holds and is not larger than the key: it stays below the insert point
  assign le = valid && (value <= key);

  // Pick the new entry: keep, take the key, or take the neighbor's entry
  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctrl.ins) begin
      if (!le) begin
        if (prev_le) begin
          value_next = key;
          valid_next = 1'b1;
        end else begin
          value_next = prev_value;
          valid_next = prev_valid;
        end
      end
    end else if (ctrl.shift) begin
      value_next = next_value;
      valid_next = next_valid;
    end
  end

  // Valid bit is control state; the value itself needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

### hw/rtl/insertion_sort_engine_top.sv
// Top level of the insertion sort engine: cell chain plus load/drain control.
`default_nettype none

// Usage:
//   Input channel (value_in, last_in) and result channel (value_out, last_out,
//   overflow) both use valid/ready. Send one set as a run of values with
//   last_in high on the final one. Each accepted value is placed in a chain of
//   MAX_ITEMS cells: every cell compares against the value at once and larger
//   entries move up one cell. Loading runs at one value per cycle.
//   Values that arrive while all cells are full are dropped and overflow is
//   raised on every result of that set.
//   The cycle after the last value is accepted, the first (smallest) result is
//   offered. Results then leave one per cycle from cell 0 while out_ready is
//   high, the chain moving down one cell per transfer; last_out marks the
//   largest. in_ready is low while results drain; a stalled receiver simply
//   freezes the chain with the current result held on the ports.
//   Reset empties the chain and clears the overflow flag; no clearing pass.
module insertion_sort_engine_top #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] value_in,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      value_out,
  output logic             last_out,
  output logic             overflow
);

  localparam int PW = 16;

  ises_pkg::ises_state_t state;
  ises_pkg::ises_state_t state_next;
  ises_pkg::ises_ctrl_t  ctrl;

  logic [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] cell_value [MAX_ITEMS];
  logic                   cell_valid [MAX_ITEMS];
  logic                   cell_le    [MAX_ITEMS];

  logic in_xfer;
  logic out_xfer;
  logic full;
  logic dropped;
  logic dropped_next;

  // Fit the input field to the key width and the head entry to the output field
  generate
    if (VALUE_WIDTH > PW) begin : g_wide
      assign key       = {{(VALUE_WIDTH-PW){1'b0}}, value_in};
      assign value_out = cell_value[0][PW-1:0];
    end else if (VALUE_WIDTH == PW) begin : g_same
      assign key       = value_in;
      assign value_out = cell_value[0];
    end else begin : g_narrow
      assign key       = value_in[VALUE_WIDTH-1:0];
      assign value_out = {{(PW-VALUE_WIDTH){1'b0}}, cell_value[0]};
    end
  endgenerate

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign full     = cell_valid[MAX_ITEMS-1];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ises_pkg::ST_LOAD: begin
        if (in_xfer && last_in) state_next = ises_pkg::ST_DRAIN;
      end
      ises_pkg::ST_DRAIN: begin
        if (out_xfer && last_out) state_next = ises_pkg::ST_LOAD;
      end
      default: state_next = ises_pkg::ST_LOAD;
    endcase
  end

  // Outputs and chain commands
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctrl.ins   = 1'b0;
    ctrl.shift = 1'b0;
    case (state)
      ises_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        ctrl.ins = in_valid && !full;
      end
      ises_pkg::ST_DRAIN: begin
        out_valid  = 1'b1;
        ctrl.shift = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Largest entry is at the head once the next cell is empty
  assign last_out = !cell_valid[1];
  assign overflow = dropped;

  // Raise the drop flag on a value that finds the chain full; clear after the set
  always_comb begin
    dropped_next = dropped;
    if (in_xfer && full) begin
      dropped_next = 1'b1;
    end else if (out_xfer && last_out) begin
      dropped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ises_pkg::ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  // Chain of cells: cell 0 is the head, its lower neighbor is the key itself
  generate
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] pv;
      logic                   pvld;
      logic                   ple;
      logic [VALUE_WIDTH-1:0] nv;
      logic                   nvld;

      if (i == 0) begin : g_head
        assign pv   = key;
        assign pvld = 1'b1;
        assign ple  = 1'b1;
      end else begin : g_body
        assign pv   = cell_value[i-1];
        assign pvld = cell_valid[i-1];
        assign ple  = cell_le[i-1];
      end

      if (i == MAX_ITEMS-1) begin : g_tail
        assign nv   = cell_value[i];
        assign nvld = 1'b0;
      end else begin : g_inner
        assign nv   = cell_value[i+1];
        assign nvld = cell_valid[i+1];
      end

      ises_cell #(
        .W (VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .key        (key),
        .prev_value (pv),
        .prev_valid (pvld),
        .prev_le    (ple),
        .next_value (nv),
        .next_valid (nvld),
        .value      (cell_value[i]),
        .valid      (cell_valid[i]),
        .le         (cell_le[i])
      );
    end
  endgenerate

endmodule

`default_nettype wire

### tb/insertion_sort_engine_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the insertion sort engine: directed sets, capacity sets, then random sets.
module insertion_sort_engine_top_test;

  localparam int SLOTS      = 64;
  localparam int SET_ITEMS  = 280;
  localparam int IDLE_LIMIT = 1000;
  localparam int ROWS       = 19;

  // One sorted result as it leaves the block.
  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        ovf;
  } sorted_word_t;

  // One input transfer; pinned rows carry their single result typed in.
  typedef struct packed {
    logic [15:0]  value;
    logic         last;
    logic         pinned;
    sorted_word_t want;
  } stim_row_t;

  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_EDGES
  } spread_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [15:0] value_in  = 16'h0000;
  logic        last_in   = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] value_out;
  logic        last_out;
  logic        overflow;

  // Shadow of the sorted store, kept in step with accepted values.
  logic [15:0]  shadow_store [SLOTS];
  int           shadow_count = 0;
  logic         shadow_lost  = 1'b0;
  sorted_word_t sorted_q [$];
  stim_row_t    pending_rows [$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int items_sent  = 0;

  // Directed sets: extremes, duplicates, descending, ascending, all equal.
  stim_row_t stim_tbl [0:ROWS-1] = '{
    '{16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{16'h0001, 1'b1, 1'b1, '{16'h0001, 1'b1, 1'b0}},
    '{16'h5555, 1'b0, 1'b0, '0},
    '{16'hAAAA, 1'b0, 1'b0, '0},
    '{16'hFFFF, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, '0},
    '{16'h5555, 1'b1, 1'b0, '0},
    '{16'h0009, 1'b0, 1'b0, '0},
    '{16'h0008, 1'b0, 1'b0, '0},
    '{16'h0007, 1'b0, 1'b0, '0},
    '{16'h0001, 1'b1, 1'b0, '0},
    '{16'h0001, 1'b0, 1'b0, '0},
    '{16'h0002, 1'b0, 1'b0, '0},
    '{16'h0003, 1'b1, 1'b0, '0},
    '{16'h1234, 1'b0, 1'b0, '0},
    '{16'h1234, 1'b0, 1'b0, '0},
    '{16'h1234, 1'b1, 1'b0, '0},
    '{16'h8000, 1'b1, 1'b1, '{16'h8000, 1'b1, 1'b0}}
  };

  insertion_sort_engine_top #(
    .MAX_ITEMS  (SLOTS),
    .VALUE_WIDTH(16)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value_in (value_in),
    .last_in  (last_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value_out(value_out),
    .last_out (last_out),
    .overflow (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
    end
  endtask

  // Insert one value in sorted order; on the last value queue the whole set.
  task automatic insert_sorted(input logic [15:0] v, input logic l, input stim_row_t row);
    int pos;
    int k;
    sorted_word_t w;
    if (shadow_count >= SLOTS) begin
      shadow_lost = 1'b1;
    end else begin
      pos = 0;
      while (pos < shadow_count && shadow_store[pos] <= v) pos++;
      for (k = shadow_count; k > pos; k--) shadow_store[k] = shadow_store[k-1];
      shadow_store[pos] = v;
      shadow_count++;
    end
    if (l) begin
      for (k = 0; k < shadow_count; k++) begin
        if (row.pinned) begin
          w = row.want;
        end else begin
          w = '{value: shadow_store[k],
                last:  (k == shadow_count - 1),
                ovf:   shadow_lost};
        end
        sorted_q = {sorted_q, w};
      end
      shadow_count = 0;
      shadow_lost  = 1'b0;
    end
  endtask

  // Predict on input transfers, check output transfers, watch for a hang.
  always @(posedge clk) begin : monitor
    stim_row_t    row;
    sorted_word_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (pending_rows.size() == 0) row = '0;
        else row = pending_rows.pop_front();
        insert_sorted(value_in, last_in, row);
      end
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          report_mismatch("result with none expected", int'(value_out), 0);
        end else begin
          want = sorted_q.pop_front();
          if (value_out !== want.value)
            report_mismatch("value_out", int'(value_out), int'(want.value));
          if (last_out !== want.last)
            report_mismatch("last_out", int'(last_out), int'(want.last));
          if (overflow !== want.ovf)
            report_mismatch("overflow", int'(overflow), int'(want.ovf));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one value after an idle gap and hold it until the transfer.
  task automatic send_value(input logic [15:0] v, input logic l, input stim_row_t row,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_rows = {pending_rows, row};
    in_valid <= 1'b1;
    value_in <= v;
    last_in  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold off until every queued result has left.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value(input spread_t spread);
    logic [15:0] v;
    case (spread)
      SPREAD_NARROW: v = 16'($urandom_range(0, 3));
      SPREAD_EDGES: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h0000;
          1:       v = 16'hFFFF;
          2:       v = 16'h8000;
          default: v = 16'h7FFF;
        endcase
      end
      default: v = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return v;
  endfunction

  // Send one set of n values, last flag on the final one.
  task automatic send_set(input int n, input spread_t spread, input logic calm);
    int i;
    for (i = 0; i < n; i++) begin
      send_value(pick_value(spread), (i == n - 1), '0, calm ? 0 : $urandom_range(0, 8));
    end
  endtask

  // Stall the result side at random, with stall-free stretches now and then.
  initial begin : receiver
    int stall;
    int calm_left;
    calm_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else begin
        stall = $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int i;
    int n;
    int pick;
    int rand_start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    for (i = 0; i < ROWS; i++) begin
      send_value(stim_tbl[i].value, stim_tbl[i].last, stim_tbl[i], $urandom_range(0, 8));
    end
    wait_drained();

    // Fill the store: last value dropped, several dropped, exactly full.
    send_set(SLOTS + 1, SPREAD_FULL, 1'b1);
    send_set(SLOTS + 6, SPREAD_NARROW, 1'b0);
    send_set(SLOTS, SPREAD_EDGES, 1'b0);
    wait_drained();

    // Random sets, mostly small, a few at or past capacity.
    rand_start = items_sent;
    while (items_sent - rand_start < SET_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) n = $urandom_range(1, 8);
      else if (pick < 18) n = $urandom_range(9, 40);
      else if (pick < 19) n = $urandom_range(SLOTS - 1, SLOTS + 1);
      else n = $urandom_range(SLOTS + 2, SLOTS + 10);
      send_set(n, spread_t'($urandom_range(0, 2)), ($urandom_range(0, 3) == 0));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
    repeat (2 * SLOTS) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ises_pkg.sv
hw/rtl/ises_cell.sv
hw/rtl/insertion_sort_engine_top.sv
tb/insertion_sort_engine_top_test.sv
